// ===== design/eaat_pkg.sv =====
// Shared types and constants for the expiring address admission table.
package eaat_pkg;

	localparam int DEFAULT_ENTRIES = 64;
	localparam logic [31:0] HOLD_TIME_RESET = 32'd30000;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_PRESENT = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic        func;
		logic [31:0] address;
		logic [31:0] now;
	} req_t;

endpackage

// ===== design/eaat_front.sv =====
// Input side: accepts requests and holds them in a two-entry queue for the engine.
module eaat_front
	import eaat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // address [31:0], now [63:32]
	input  logic        s_tuser,   // func
	input  logic        init_done,
	output logic        req_valid,
	output req_t        req,
	input  logic        req_pop
);

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	req_t       incoming;

	always_comb begin
		incoming.func    = s_tuser;
		incoming.address = s_tdata[31:0];
		incoming.now     = s_tdata[63:32];
	end

	// No transaction is taken while the table is still being cleared.
	assign s_tready  = init_done && (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign req_valid = (count_q != 2'd0);
	assign req       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (req_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !req_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && req_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

// ===== design/eaat_engine.sv =====
// Table engine: scans the entry memory one slot per cycle and produces add results.
module eaat_engine
	import eaat_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] hold_time,
	input  logic        req_valid,
	input  req_t        req,
	output logic        req_pop,
	output logic        init_done,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // status [1:0], zero [7:2]
);

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNTW = $clog2(ENTRIES + 1);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
	localparam logic [CNTW-1:0] ISSUE_END = CNTW'(ENTRIES);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	typedef struct packed {
		logic        valid;
		logic [31:0] address;
		logic [31:0] expiry;
	} entry_t;

	entry_t mem [ENTRIES];

	logic [2:0]      state_q;
	logic [IDXW-1:0] clr_idx_q;
	req_t            op_q;
	logic [CNTW-1:0] iss_q;
	logic            rdv_s1;
	logic [IDXW-1:0] idx_s1;
	entry_t          rd_data_s1;
	logic            free_found_q;
	logic [IDXW-1:0] free_idx_q;
	logic [1:0]      res_q;
	logic            out_valid_q;
	logic [1:0]      out_status_q;

	logic            rd_en;
	logic            wr_en;
	logic [IDXW-1:0] wr_idx;
	entry_t          wr_data;
	logic            eval;
	logic            present_hit;
	logic            slot_free;
	logic            scan_last;
	logic            out_load;

	assign init_done = (state_q != ST_CLEAR);
	assign req_pop   = (state_q == ST_IDLE) && req_valid;
	assign rd_en     = (state_q == ST_SCAN) && (iss_q != ISSUE_END);
	assign eval      = (state_q == ST_SCAN) && rdv_s1;
	assign scan_last = eval && (idx_s1 == LAST_IDX);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, out_status_q};

	always_comb begin
		wr_en         = 1'b0;
		wr_idx        = idx_s1;
		wr_data       = rd_data_s1;
		wr_data.valid = 1'b0;
		present_hit   = 1'b0;
		slot_free     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_idx  = clr_idx_q;
				wr_data = '0;
			end
			ST_SCAN: begin
				if (eval) begin
					if (op_q.func == FUNC_ADD) begin
						if (rd_data_s1.valid) begin
							// An expired entry is released as the scan passes it.
							if (op_q.now > rd_data_s1.expiry) begin
								wr_en     = 1'b1;
								slot_free = 1'b1;
							end else if (rd_data_s1.address == op_q.address) begin
								present_hit = 1'b1;
							end
						end else begin
							slot_free = 1'b1;
						end
					end else if (rd_data_s1.valid &&
					             (rd_data_s1.address == op_q.address)) begin
						wr_en = 1'b1;
					end
				end
			end
			ST_FINISH: begin
				if (free_found_q) begin
					wr_en           = 1'b1;
					wr_idx          = free_idx_q;
					wr_data.valid   = 1'b1;
					wr_data.address = op_q.address;
					wr_data.expiry  = op_q.now + hold_time;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[iss_q[IDXW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			iss_q        <= '0;
			rdv_s1       <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						iss_q        <= '0;
						rdv_s1       <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (slot_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					// A live match ends the scan; later entries stay untouched.
					if (present_hit) begin
						rdv_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else if (scan_last) begin
						rdv_s1  <= 1'b0;
						state_q <= (op_q.func == FUNC_ADD) ? ST_FINISH : ST_IDLE;
					end else begin
						rdv_s1 <= rd_en;
					end
				end
				ST_FINISH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			op_q <= req;
		end
		if (rd_en) begin
			idx_s1 <= iss_q[IDXW-1:0];
		end
		if (slot_free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (present_hit) begin
			res_q <= STATUS_PRESENT;
		end else if (state_q == ST_FINISH) begin
			res_q <= free_found_q ? STATUS_INSERTED : STATUS_FULL;
		end
		if (out_load) begin
			out_status_q <= res_q;
		end
	end

endmodule

// ===== design/expiring_address_admission_table.sv =====
// Requests wait in the front queue; the engine takes one at a time and scans the entry
// memory, reading and checking one slot per cycle. An add then claims the first free slot,
// if any, and registers its status; a delete gives no status.
// Reset: hold_time returns to 30000 and all entries are invalidated by a clearing
// pass over all ENTRIES slots, during which no transaction is accepted.
module expiring_address_admission_table
	import eaat_pkg::*;
#(
	parameter int ENTRIES = DEFAULT_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,   // hold_time
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,     // address [31:0], now [63:32]
	input  logic        s_tuser,     // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata      // status [1:0], zero [7:2]
);

	logic [31:0] hold_time_q;
	logic        init_done;
	logic        req_valid;
	req_t        req;
	logic        req_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= HOLD_TIME_RESET;
		end else if (cfg_we) begin
			hold_time_q <= cfg_wdata;
		end
	end

	eaat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_done (init_done),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	eaat_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold_time (hold_time_q),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop),
		.init_done (init_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	a_no_accept_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) !init_done |-> !s_tready
	) else $error("transaction accepted during the clearing pass");

	a_pop_needs_request: assert property (
		@(posedge clk) disable iff (!arst_n) req_pop |-> req_valid
	) else $error("engine took a request from an empty queue");

	a_status_code_legal: assert property (
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == STATUS_INSERTED || m_tdata[1:0] == STATUS_PRESENT ||
		              m_tdata[1:0] == STATUS_FULL)
	) else $error("illegal status code on the result");

	a_init_stays_done: assert property (
		@(posedge clk) disable iff (!arst_n) init_done |=> init_done
	) else $error("clearing pass restarted without reset");

endmodule

// ===== test/tb_expiring_address_admission_table.sv =====
// Self-checking testbench for the expiring address admission table.
`timescale 1ns / 100ps

module tb_expiring_address_admission_table;
	import eaat_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4 * DEFAULT_ENTRIES + 16;
	localparam int POOL_SIZE = 96;

	typedef enum {MIX_FILL, MIX_POOL, MIX_NOISE} mix_t;

	// Mirrors the table contents and keeps the statuses still owed by the block.
	class admission_scoreboard;
		logic [31:0] hold_time;
		bit          slot_valid [DEFAULT_ENTRIES];
		logic [31:0] slot_address [DEFAULT_ENTRIES];
		logic [31:0] slot_expiry [DEFAULT_ENTRIES];
		logic [1:0]  status_queue [$];
		int          errors;

		function new();
			hold_time = HOLD_TIME_RESET;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			errors = 0;
		endfunction

		function void note_request(req_t req);
			int free_slot = -1;
			if (req.func == FUNC_DELETE) begin
				foreach (slot_valid[i])
					if (slot_valid[i] && slot_address[i] == req.address) slot_valid[i] = 1'b0;
				return;
			end
			// Expired slots are freed as the scan passes them; a live match ends the scan.
			for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
				if (slot_valid[i]) begin
					if (req.now > slot_expiry[i]) begin
						slot_valid[i] = 1'b0;
						if (free_slot < 0) free_slot = i;
					end else if (slot_address[i] == req.address) begin
						status_queue.push_back(STATUS_PRESENT);
						return;
					end
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (free_slot < 0) begin
				status_queue.push_back(STATUS_FULL);
				return;
			end
			slot_valid[free_slot] = 1'b1;
			slot_address[free_slot] = req.address;
			slot_expiry[free_slot] = req.now + hold_time;
			status_queue.push_back(STATUS_INSERTED);
		endfunction

		function void check_status(logic [7:0] got);
			logic [7:0] want;
			if (status_queue.size() == 0) begin
				$display("%0t: unexpected status transaction, expected none, got %0d",
					$time, got);
				errors++;
				return;
			end
			want = {6'b0, status_queue.pop_front()};
			if (got !== want) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	admission_scoreboard book;
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	expiring_address_admission_table #(
		.ENTRIES(DEFAULT_ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Status side: check the transaction seen at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) book.check_status(m_tdata);
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic send_request(logic func, logic [31:0] address, logic [31:0] now);
		req_t req;
		req.func = func;
		req.address = address;
		req.now = now;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now, address};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		book.note_request(req);
	endtask

	// Deletes give no status, so a fixed drain follows the last expected status.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (book.status_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] hold, int send_pct, int recv_pct, int count,
		mix_t mix, int step_max);
		logic [31:0] addr_pool [POOL_SIZE];
		logic [31:0] tick;
		logic [31:0] address;
		logic        func;
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.hold_time = hold;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		foreach (addr_pool[i]) addr_pool[i] = $urandom();
		// Filling starts low so that long hold times do not wrap; pool traffic starts
		// high enough to age out whatever an earlier fill left behind.
		if (mix == MIX_FILL)
			tick = $urandom_range(0, 32'h0FFF_FFFF);
		else
			tick = $urandom_range(32'h9000_0000, 32'hFFFF_FFFF);
		for (int n = 0; n < count; n++) begin
			case (mix)
				MIX_FILL: begin
					func = FUNC_ADD;
					address = $urandom();
					tick = tick + $urandom_range(0, step_max);
				end
				MIX_POOL: begin
					func = ($urandom_range(0, 99) < 20) ? FUNC_DELETE : FUNC_ADD;
					if ($urandom_range(0, 99) < 10)
						address = $urandom();
					else
						address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
					if ($urandom_range(0, 99) < 4)
						tick = $urandom();
					else
						tick = tick + $urandom_range(0, step_max);
				end
				default: begin
					func = ($urandom_range(0, 1) == 0) ? FUNC_ADD : FUNC_DELETE;
					address = $urandom();
					tick = $urandom();
				end
			endcase
			send_request(func, address, tick);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_ADD;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		book = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset hold time.
		send_request(FUNC_ADD, 32'h0A00_0001, 32'd1000);
		// A tick equal to the expiry still counts as live.
		send_request(FUNC_ADD, 32'h0A00_0001, 32'd31000);
		send_request(FUNC_ADD, 32'h0A00_0001, 32'd31001);
		send_request(FUNC_DELETE, 32'h0B00_0002, 32'd31001);
		send_request(FUNC_DELETE, 32'h0A00_0001, 32'd31001);
		send_request(FUNC_ADD, 32'h0A00_0001, 32'd31002);
		send_request(FUNC_ADD, 32'h0000_0000, 32'd0);
		// The expiry wraps past zero here and is already stale on the next add.
		send_request(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_ADD, 32'h0C00_0003, 32'd0);
		send_request(FUNC_ADD, 32'h0D00_0004, 32'd20000);
		send_request(FUNC_ADD, 32'hFFFF_FFFF, 32'd29999);
		send_request(FUNC_DELETE, 32'hFFFF_FFFF, 32'd29999);
		send_request(FUNC_ADD, 32'h0E00_0005, 32'd20000);
		// A live match in a low slot leaves the expired slot after it untouched.
		send_request(FUNC_ADD, 32'h0E00_0005, 32'd40000);
		send_request(FUNC_ADD, 32'h0C00_0003, 32'd40000);
		send_request(FUNC_DELETE, 32'h0D00_0004, 32'd40000);
		send_request(FUNC_ADD, 32'h1234_5678, 32'h8000_0000);
		send_request(FUNC_DELETE, 32'hFFFF_FFFF, 32'h8000_0000);

		run_phase(32'h7FFF_FFFF, 0, 0, 75, MIX_FILL, 3);
		run_phase(32'd30000, 46, 0, 90, MIX_POOL, 700);
		run_phase(32'd0, 0, 46, 80, MIX_POOL, 2);
		run_phase(32'hFFFF_FFFF, 12, 12, 80, MIX_POOL, 1000);
		run_phase($urandom_range(1, 5000), 0, 0, 80, MIX_POOL, 100);
		run_phase($urandom(), 46, 46, 45, MIX_NOISE, 0);

		settle();
		if (book.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
